// File: rtl/core/lru_key_value_cache_top_macros.svh
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared helpers for the concurrent checks of the cache modules.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH

`define LKVC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lkvc check failed");

`define LKVC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    `LKVC_ASSERT(label, clk, rst_n, (pre) |=> (post))

`endif

// File: rtl/core/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Widths, sizes, operation codes and the queued item type.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    localparam logic [CAP_W-1:0]        CAP_RESET = CAP_W'(16);
    localparam logic signed [VAL_W-1:0] MISS_VAL  = -VAL_W'(1);

    typedef struct packed {
        logic                    op;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_item;

endpackage

// File: rtl/core/lkvc_ifs.sv
// ----------------------------------------------------------------------------
// LRU key-value cache channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lkvc_req_if;
    logic                             valid;
    logic                             ready;
    logic                             op;
    logic signed [lkvc_pkg::KEY_W-1:0] key;
    logic signed [lkvc_pkg::VAL_W-1:0] value;

    modport source (output valid, output op, output key, output value, input ready);
    modport sink   (input valid, input op, input key, input value, output ready);
endinterface

interface lkvc_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             hit;
    logic signed [lkvc_pkg::VAL_W-1:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

interface lkvc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lkvc_pkg::CAP_W-1:0]     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/lru_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// LRU key-value cache top level
// Sixteen-entry fully associative key-value store with LRU replacement.
// ----------------------------------------------------------------------------
// The cache takes one get or set per clock while the response channel is not
// stalled and returns exactly one result per request, in order; each request
// passes through a two-entry queue and then the result register. The queue
// feeds a lookup engine that compares the key against all sixteen entries,
// picks a free or least recent slot and updates the recency ranks; that
// engine and its result register set the rate of one transfer per clock. The
// capacity register may only be written while no request is in flight.
module lru_key_value_cache_top (
    input logic        i_clk,
    input logic        i_rst_n,
    lkvc_req_if.sink   i_req,
    lkvc_cfg_if.sink   i_cfg,
    lkvc_rsp_if.source o_rsp
);
    import lkvc_pkg::*;

    lkvc_req_if u_q ();

    lkvc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_req   (u_q)
    );

    lkvc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_q),
        .i_cfg   (i_cfg),
        .o_rsp   (o_rsp)
    );

endmodule

// File: rtl/core/lkvc_front.sv
// ----------------------------------------------------------------------------
// LRU key-value cache front end
// Accepts requests and holds them in a short queue ahead of the lookup engine.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_top_macros.svh"

module lkvc_front (
    input logic        i_clk,
    input logic        i_rst_n,
    lkvc_req_if.sink   i_req,
    lkvc_req_if.source o_req
);
    import lkvc_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic              push;
    logic              pop;
    t_item             in_item;
    t_item             head;

    assign i_req.ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign push        = i_req.valid && i_req.ready;
    assign pop         = o_req.valid && o_req.ready;

    assign in_item.op    = i_req.op;
    assign in_item.key   = i_req.key;
    assign in_item.value = i_req.value;

    assign head        = r_mem[r_rd_ptr];
    assign o_req.valid = (r_count != '0);
    assign o_req.op    = head.op;
    assign o_req.key   = head.key;
    assign o_req.value = head.value;

    assign n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `LKVC_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= QCNT_W'(QUEUE_DEPTH))
    `LKVC_ASSERT(a_empty_ptrs, i_clk, i_rst_n, (r_count != '0) || (r_rd_ptr == r_wr_ptr))
    `LKVC_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, push && !pop, r_count == $past(r_count) + 1'b1)

endmodule

// File: rtl/core/lkvc_back.sv
// ----------------------------------------------------------------------------
// LRU key-value cache lookup engine
// Parallel tag compare, fill or eviction, recency rank update and result register.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_top_macros.svh"

module lkvc_back (
    input logic        i_clk,
    input logic        i_rst_n,
    lkvc_req_if.sink   i_req,
    lkvc_cfg_if.sink   i_cfg,
    lkvc_rsp_if.source o_rsp
);
    import lkvc_pkg::*;

    logic signed [KEY_W-1:0] r_key  [MAX_ENTRIES];
    logic signed [VAL_W-1:0] r_val  [MAX_ENTRIES];
    logic [IDX_W-1:0]        r_rank [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]  r_vld;
    logic [CNT_W-1:0]        r_used;
    logic [CAP_W-1:0]        r_cap;
    logic                    r_out_vld;
    logic                    r_hit;
    logic signed [VAL_W-1:0] r_rdval;

    logic [MAX_ENTRIES-1:0]  hit_vec;
    logic [MAX_ENTRIES-1:0]  vict_vec;
    logic                    hit;
    logic [IDX_W-1:0]        hit_idx;
    logic [IDX_W-1:0]        free_idx;
    logic [IDX_W-1:0]        vict_idx;
    logic [IDX_W-1:0]        tgt;
    logic [IDX_W-1:0]        vict_rank;
    logic [CNT_W-1:0]        used_m1;
    logic [CNT_W-1:0]        eff_cap;
    logic [CNT_W-1:0]        limit;
    logic                    pop;
    logic                    is_set;
    logic                    do_fill;
    logic                    do_update;
    logic signed [VAL_W-1:0] rd_val;

    assign i_cfg.ready = 1'b1;

    assign pop         = i_req.valid && i_req.ready;
    assign i_req.ready = !r_out_vld || o_rsp.ready;
    assign is_set      = (i_req.op == OP_SET);

    assign used_m1   = r_used - CNT_W'(1);
    assign vict_rank = used_m1[IDX_W-1:0];

    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CNT_W'(1);
        end else if (CNT_W'(r_cap) > CNT_W'(MAX_ENTRIES)) begin
            eff_cap = CNT_W'(MAX_ENTRIES);
        end else begin
            eff_cap = CNT_W'(r_cap);
        end
    end

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        vict_idx = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            hit_vec[i]  = r_vld[i] && (r_key[i] == i_req.key);
            vict_vec[i] = r_vld[i] && (r_rank[i] == vict_rank);
        end
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_idx = IDX_W'(i);
            end
            if (!r_vld[i]) begin
                free_idx = IDX_W'(i);
            end
            if (vict_vec[i]) begin
                vict_idx = IDX_W'(i);
            end
        end
    end

    assign hit       = |hit_vec;
    assign do_fill   = is_set && !hit && (r_used < eff_cap);
    assign do_update = pop && (is_set || hit);
    assign tgt       = hit ? hit_idx : (do_fill ? free_idx : vict_idx);
    assign limit     = do_fill ? CNT_W'(MAX_ENTRIES) : CNT_W'(r_rank[tgt]);

    always_comb begin
        if (is_set) begin
            rd_val = '0;
        end else if (hit) begin
            rd_val = r_val[hit_idx];
        end else begin
            rd_val = MISS_VAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_update && is_set) begin
            r_key[tgt] <= i_req.key;
            r_val[tgt] <= i_req.value;
        end
        if (pop) begin
            r_hit   <= hit;
            r_rdval <= rd_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_used    <= '0;
            r_cap     <= CAP_RESET;
            r_out_vld <= 1'b0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                r_cap <= i_cfg.data;
            end
            if (pop) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            if (do_update) begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (IDX_W'(i) == tgt) begin
                        r_rank[i] <= '0;
                    end else if (r_vld[i] && (CNT_W'(r_rank[i]) < limit)) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
                if (do_fill) begin
                    r_vld[tgt] <= 1'b1;
                    r_used     <= r_used + 1'b1;
                end
            end
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.hit        = r_hit;
    assign o_rsp.read_value = r_rdval;

    `LKVC_ASSERT(a_used_bound, i_clk, i_rst_n, r_used <= CNT_W'(MAX_ENTRIES))
    `LKVC_ASSERT(a_used_matches, i_clk, i_rst_n, $countones(r_vld) == int'(r_used))
    `LKVC_ASSERT(a_single_hit, i_clk, i_rst_n, i_req.valid |-> $onehot0(hit_vec))
    `LKVC_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, pop, r_out_vld)

endmodule

// File: dv/lru_key_value_cache_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives gets and sets through the request channel and checks every response
// against a cycle-free model of the cache. A directed opening covers empty,
// hit, miss, update and eviction cases and the capacity corner values.
// Randomized phases then follow over several capacities and handshake
// pressure modes.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top_tb;
    import lkvc_pkg::*;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
    } t_access_result;

    logic clk;
    logic rst_n;

    lkvc_req_if req_if ();
    lkvc_rsp_if rsp_if ();
    lkvc_cfg_if cfg_if ();

    lru_key_value_cache_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .i_cfg   (cfg_if),
        .o_rsp   (rsp_if)
    );

    t_item                   access_backlog[$];
    t_access_result          replies_due[$];
    logic signed [KEY_W-1:0] key_pool[$];

    logic [KEY_W-1:0] cache_key[MAX_ENTRIES];
    logic [VAL_W-1:0] cache_val[MAX_ENTRIES];
    bit               cache_live[MAX_ENTRIES];
    int               cache_age[MAX_ENTRIES];
    int               cache_fill;
    logic [CAP_W-1:0] cache_cap;

    int sender_idle_pct;
    int receiver_stall_pct;
    int fault_count;

    function automatic void promote_slot(int s, int limit);
        int i;
        for (i = 0; i < MAX_ENTRIES; i++) begin
            if (i != s && cache_live[i] && cache_age[i] < limit) begin
                cache_age[i]++;
            end
        end
        cache_age[s] = 0;
    endfunction

    function automatic t_access_result lru_predict(t_item it);
        t_access_result res;
        int             i;
        int             slot;
        int             victim;
        int             eff_cap;
        slot = -1;
        for (i = 0; i < MAX_ENTRIES; i++) begin
            if (slot < 0 && cache_live[i] && cache_key[i] == it.key) begin
                slot = i;
            end
        end
        res.hit = (slot >= 0);
        if (it.op == OP_GET) begin
            if (slot >= 0) begin
                res.read_value = cache_val[slot];
                promote_slot(slot, cache_age[slot]);
            end else begin
                res.read_value = MISS_VAL;
            end
            return res;
        end
        res.read_value = '0;
        if (slot >= 0) begin
            cache_val[slot] = it.value;
            promote_slot(slot, cache_age[slot]);
            return res;
        end
        eff_cap = (cache_cap == 0) ? 1 : int'(cache_cap);
        if (eff_cap > MAX_ENTRIES) begin
            eff_cap = MAX_ENTRIES;
        end
        if (cache_fill < eff_cap) begin
            for (i = 0; i < MAX_ENTRIES; i++) begin
                if (slot < 0 && !cache_live[i]) begin
                    slot = i;
                end
            end
            if (slot >= 0) begin
                cache_key[slot] = it.key;
                cache_val[slot] = it.value;
                promote_slot(slot, MAX_ENTRIES);
                cache_live[slot] = 1'b1;
                cache_fill++;
                return res;
            end
        end
        victim = -1;
        for (i = 0; i < MAX_ENTRIES; i++) begin
            if (cache_live[i] && (victim < 0 || cache_age[i] > cache_age[victim])) begin
                victim = i;
            end
        end
        if (victim >= 0) begin
            cache_key[victim] = it.key;
            cache_val[victim] = it.value;
            promote_slot(victim, cache_age[victim]);
        end
        return res;
    endfunction

    function automatic logic [31:0] corner_word();
        logic [31:0] corners[5];
        corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001};
        return corners[$urandom_range(0, 4)];
    endfunction

    function automatic t_item random_access();
        t_item it;
        int    pick;
        it.op = $urandom_range(0, 1) ? OP_SET : OP_GET;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            it.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end else if (pick < 85) begin
            it.key = corner_word();
        end else begin
            it.key = $urandom;
        end
        it.value = ($urandom_range(0, 9) == 0) ? corner_word() : $urandom;
        return it;
    endfunction

    task automatic push_access(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
        t_item it;
        it.op = op;
        it.key = key;
        it.value = value;
        access_backlog.push_back(it);
    endtask

    task automatic wait_idle();
        while (access_backlog.size() != 0 || replies_due.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        wait_idle();
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= cap;
        do begin
            @(posedge clk);
        end while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        cache_cap = cap;
    endtask

    initial begin
        clk = 1'b0;
    end

    always begin
        #5 clk = ~clk;
    end

    always @(posedge clk) begin : drive_requests
        bit             fired;
        t_access_result res;
        if (!rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            fired = req_if.valid && req_if.ready;
            if (fired) begin
                res = lru_predict(access_backlog[0]);
                replies_due.push_back(res);
                void'(access_backlog.pop_front());
            end
            if (req_if.valid && !fired) begin
                // The pending transfer keeps its payload until it is taken.
            end else if (access_backlog.size() > 0 &&
                         $urandom_range(0, 99) >= sender_idle_pct) begin
                req_if.valid <= 1'b1;
                req_if.op <= access_backlog[0].op;
                req_if.key <= access_backlog[0].key;
                req_if.value <= access_backlog[0].value;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin : check_replies
        t_access_result want;
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (replies_due.size() == 0) begin
                    if (fault_count < 10) begin
                        $display("%0t: response with nothing outstanding: hit=%0b value=%h",
                                 $realtime, rsp_if.hit, rsp_if.read_value);
                    end
                    fault_count++;
                end else begin
                    want = replies_due.pop_front();
                    if (rsp_if.hit !== want.hit) begin
                        if (fault_count < 10) begin
                            $display("%0t: hit mismatch: expected %0b, got %0b",
                                     $realtime, want.hit, rsp_if.hit);
                        end
                        fault_count++;
                    end
                    if (rsp_if.read_value !== want.read_value) begin
                        if (fault_count < 10) begin
                            $display("%0t: read_value mismatch: expected %h, got %h",
                                     $realtime, want.read_value, rsp_if.read_value);
                        end
                        fault_count++;
                    end
                end
            end
            rsp_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int cap_plan[9];
        int phase;
        int n;
        int pool_size;
        cap_plan = '{1, 2, 5, 8, 16, 31, 0, 17, 0};
        fault_count = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        cache_fill = 0;
        cache_cap = CAP_RESET;
        for (n = 0; n < MAX_ENTRIES; n++) begin
            cache_live[n] = 1'b0;
            cache_age[n] = 0;
        end
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.op = OP_GET;
        req_if.key = '0;
        req_if.value = '0;
        rsp_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        push_access(OP_GET, 32'h0000_0000, 32'h0000_0000);
        push_access(OP_SET, 32'h0000_0000, 32'h7FFF_FFFF);
        push_access(OP_SET, 32'hFFFF_FFFF, 32'h8000_0000);
        push_access(OP_SET, 32'h8000_0000, 32'hFFFF_FFFF);
        push_access(OP_SET, 32'h7FFF_FFFF, 32'h0000_0000);
        push_access(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        push_access(OP_GET, 32'h0000_0000, 32'h0000_0000);
        push_access(OP_GET, 32'h0000_0001, 32'h0000_0000);
        push_access(OP_SET, 32'h0000_0000, 32'h5A5A_5A5A);
        push_access(OP_GET, 32'h0000_0000, 32'hA5A5_A5A5);
        // A zero capacity acts as one, which is below the current fill level.
        write_capacity(CAP_W'(0));
        push_access(OP_SET, 32'h0000_0005, 32'h0000_0001);
        push_access(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        push_access(OP_GET, 32'h0000_0005, 32'h0000_0000);
        write_capacity(CAP_W'(31));
        push_access(OP_SET, 32'h0000_0006, 32'h0000_0002);
        push_access(OP_GET, 32'h0000_0006, 32'h0000_0000);
        write_capacity(CAP_W'(17));
        push_access(OP_SET, 32'h0000_0007, 32'h0000_0003);
        push_access(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        write_capacity(CAP_W'(1));
        push_access(OP_SET, 32'h0000_0008, 32'h0000_0004);
        push_access(OP_GET, 32'h0000_0008, 32'h0000_0000);

        for (phase = 0; phase < 9; phase++) begin
            if (phase == 8) begin
                cap_plan[phase] = $urandom_range(1, MAX_ENTRIES);
            end
            write_capacity(CAP_W'(cap_plan[phase]));
            case (phase % 4)
                0: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 74;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 74;
                end
                default: begin
                    sender_idle_pct = 6;
                    receiver_stall_pct = 6;
                end
            endcase
            key_pool.delete();
            pool_size = $urandom_range(4, 20);
            for (n = 0; n < pool_size; n++) begin
                key_pool.push_back($urandom);
            end
            for (n = 0; n < 165; n++) begin
                access_backlog.push_back(random_access());
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_ifs.sv
rtl/core/lkvc_front.sv
rtl/core/lkvc_back.sv
rtl/core/lru_key_value_cache_top.sv
dv/lru_key_value_cache_top_tb.sv
